[rtl/mtf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morphing tone filter package
// Control word layout, microcode program, register map and fixed constants
// shared by the sequencer, the datapath and the top level.
// ----------------------------------------------------------------------------
package mtf_pkg;

  // program counter and configuration port sizes
  localparam int PC_W      = 5;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int COEF_W    = 18;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MORPH               = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWPASS_ALPHA       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGHPASS_ALPHA      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGHPASS_ALPHA = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_LOWPASS_ALPHA  = 3'd5;

  // register reset values
  localparam logic [CFG_W-1:0] GAIN_RESET       = 16'd16384;
  localparam logic [CFG_W-1:0] MORPH_RESET      = 16'd0;
  localparam logic [CFG_W-1:0] LP_ALPHA_RESET   = 16'd8069;
  localparam logic [CFG_W-1:0] HP_ALPHA_RESET   = 16'd65193;
  localparam logic [CFG_W-1:0] BH_ALPHA_RESET   = 16'd61787;
  localparam logic [CFG_W-1:0] BL_ALPHA_RESET   = 16'd45424;

  // arithmetic constants
  localparam logic [CFG_W-1:0]         GAIN_MAX    = 16'd32768;
  localparam logic signed [COEF_W-1:0] ALPHA_ONE   = 18'sd65536;
  localparam logic signed [COEF_W-1:0] MIX_ONE     = 18'sd32768;
  localparam logic [4:0]               GAIN_SHIFT  = 5'd14;
  localparam logic [4:0]               MIX_SHIFT   = 5'd15;
  localparam logic [4:0]               ALPHA_SHIFT = 5'd16;

  // program addresses the sequencer jumps to
  localparam logic [PC_W-1:0] STEP_IDLE    = 5'd0;
  localparam logic [PC_W-1:0] STEP_FINAL   = 5'd16;
  localparam logic [PC_W-1:0] STEP_MIX_NEG = 5'd17;

  // coefficient operand of the multiplier
  typedef enum logic [3:0] {
    A_ZERO,
    A_GAIN,
    A_LP,
    A_LP_INV,
    A_HP,
    A_BH,
    A_BL,
    A_BL_INV,
    A_MIX,
    A_HALF
  } a_sel_t;

  // signal operand of the multiplier
  typedef enum logic [2:0] {
    B_INPUT,
    B_P,
    B_LP,
    B_HP_OUT,
    B_HP_IN,
    B_BH_OUT,
    B_BH_IN,
    B_BP
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  // rounded accumulator destination
  typedef enum logic [2:0] {
    WB_NONE,
    WB_P,
    WB_LP,
    WB_HP,
    WB_BH,
    WB_BP,
    WB_OUT
  } wb_t;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_ACCEPT,
    JMP_MORPH_NEG,
    JMP_GOTO,
    JMP_OUT_FREE
  } jump_t;

  typedef struct packed {
    a_sel_t            a_sel;
    b_sel_t            b_sel;
    acc_op_t           acc_op;
    wb_t               wb;
    logic              save_p;
    jump_t             jump;
    logic [PC_W-1:0]   target;
  } ucode_t;

  // conditions the sequencer branches on
  typedef struct packed {
    logic in_valid;
    logic morph_neg;
    logic out_free;
  } seq_status_t;

  // handshake events raised by the sequencer
  typedef struct packed {
    logic idle;
    logic accept;
    logic deliver;
  } seq_flags_t;

  typedef struct packed {
    logic [CFG_W-1:0] input_gain;
    logic [CFG_W-1:0] morph;
    logic [CFG_W-1:0] lowpass_alpha;
    logic [CFG_W-1:0] highpass_alpha;
    logic [CFG_W-1:0] band_highpass_alpha;
    logic [CFG_W-1:0] band_lowpass_alpha;
  } cfg_t;

  function automatic ucode_t uword(input a_sel_t a, input b_sel_t b, input acc_op_t op,
                                   input wb_t wb, input logic save, input jump_t j,
                                   input logic [PC_W-1:0] t);
    ucode_t w;
    w.a_sel  = a;
    w.b_sel  = b;
    w.acc_op = op;
    w.wb     = wb;
    w.save_p = save;
    w.jump   = j;
    w.target = t;
    return w;
  endfunction

  // microcode program: the multiplier issues a product each step, the
  // accumulator takes the previous step's product, and the write-back
  // rounds and saturates the accumulator as it stood before this step
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = uword(A_ZERO, B_P, ACC_HOLD, WB_NONE, 1'b0, JMP_GOTO, STEP_IDLE);
    unique case (pc)
      // wait for an item, gain times input issues from the port
      5'd0:  w = uword(A_GAIN,   B_INPUT,  ACC_HOLD, WB_NONE, 1'b0, JMP_ACCEPT,    STEP_IDLE);
      // highpass: ah * (hp_prev + p - p_prev)
      5'd1:  w = uword(A_HP,     B_HP_OUT, ACC_LOAD, WB_NONE, 1'b0, JMP_NEXT,      STEP_IDLE);
      5'd2:  w = uword(A_HP,     B_HP_IN,  ACC_LOAD, WB_P,    1'b0, JMP_NEXT,      STEP_IDLE);
      5'd3:  w = uword(A_HP,     B_P,      ACC_SUB,  WB_NONE, 1'b0, JMP_NEXT,      STEP_IDLE);
      // band highpass stage
      5'd4:  w = uword(A_BH,     B_BH_OUT, ACC_ADD,  WB_NONE, 1'b0, JMP_NEXT,      STEP_IDLE);
      5'd5:  w = uword(A_BH,     B_BH_IN,  ACC_LOAD, WB_HP,   1'b0, JMP_NEXT,      STEP_IDLE);
      5'd6:  w = uword(A_BH,     B_P,      ACC_SUB,  WB_NONE, 1'b0, JMP_NEXT,      STEP_IDLE);
      // lowpass
      5'd7:  w = uword(A_LP,     B_LP,     ACC_ADD,  WB_NONE, 1'b0, JMP_NEXT,      STEP_IDLE);
      5'd8:  w = uword(A_LP_INV, B_P,      ACC_LOAD, WB_BH,   1'b0, JMP_NEXT,      STEP_IDLE);
      // band lowpass stage
      5'd9:  w = uword(A_BL,     B_BP,     ACC_ADD,  WB_NONE, 1'b0, JMP_NEXT,      STEP_IDLE);
      5'd10: w = uword(A_BL_INV, B_BH_OUT, ACC_LOAD, WB_LP,   1'b0, JMP_NEXT,      STEP_IDLE);
      5'd11: w = uword(A_ZERO,   B_P,      ACC_ADD,  WB_NONE, 1'b0, JMP_MORPH_NEG,
                       STEP_MIX_NEG);
      // morph at or above zero: bp * 2^15 + c * (hp - bp)
      5'd12: w = uword(A_MIX,    B_HP_OUT, ACC_HOLD, WB_BP,   1'b0, JMP_NEXT,      STEP_IDLE);
      5'd13: w = uword(A_HALF,   B_BP,     ACC_LOAD, WB_NONE, 1'b0, JMP_NEXT,      STEP_IDLE);
      5'd14: w = uword(A_MIX,    B_BP,     ACC_ADD,  WB_NONE, 1'b0, JMP_NEXT,      STEP_IDLE);
      5'd15: w = uword(A_ZERO,   B_P,      ACC_SUB,  WB_NONE, 1'b0, JMP_NEXT,      STEP_IDLE);
      // hand over the result and keep the input history
      5'd16: w = uword(A_ZERO,   B_P,      ACC_HOLD, WB_OUT,  1'b1, JMP_OUT_FREE,  STEP_IDLE);
      // morph below zero: lp * 2^15 + c * (bp - lp)
      5'd17: w = uword(A_HALF,   B_LP,     ACC_HOLD, WB_BP,   1'b0, JMP_NEXT,      STEP_IDLE);
      5'd18: w = uword(A_MIX,    B_BP,     ACC_LOAD, WB_NONE, 1'b0, JMP_NEXT,      STEP_IDLE);
      5'd19: w = uword(A_MIX,    B_LP,     ACC_ADD,  WB_NONE, 1'b0, JMP_NEXT,      STEP_IDLE);
      5'd20: w = uword(A_ZERO,   B_P,      ACC_SUB,  WB_NONE, 1'b0, JMP_GOTO,      STEP_FINAL);
      default: w = uword(A_ZERO, B_P,      ACC_HOLD, WB_NONE, 1'b0, JMP_GOTO,      STEP_IDLE);
    endcase
    return w;
  endfunction

endpackage

[rtl/mtf_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morphing tone filter sequencer
// Step counter over the microcode program with conditional jumps on item
// arrival, morph sign and output availability.
// ----------------------------------------------------------------------------
module mtf_sequencer
  import mtf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  seq_status_t status,
  output ucode_t      ctrl,
  output seq_flags_t  flags
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucode_t          word;

  // control word of the current step
  assign word = ucode_rom(pc);
  assign ctrl = word;

  // next step selection
  always_comb begin
    unique case (word.jump)
      JMP_NEXT:      pc_next = pc + PC_W'(1);
      JMP_ACCEPT:    pc_next = status.in_valid ? pc + PC_W'(1) : pc;
      JMP_MORPH_NEG: pc_next = status.morph_neg ? word.target : pc + PC_W'(1);
      JMP_GOTO:      pc_next = word.target;
      JMP_OUT_FREE:  pc_next = status.out_free ? word.target : pc;
      default:       pc_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // handshake events
  assign flags.idle    = (word.jump == JMP_ACCEPT);
  assign flags.accept  = (word.jump == JMP_ACCEPT) && status.in_valid;
  assign flags.deliver = (word.jump == JMP_OUT_FREE) && status.out_free;

endmodule

[rtl/mtf_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morphing tone filter datapath
// One shared multiplier with a product register, an accumulator, a rounding
// and saturating write-back, and the per-channel filter state.
// ----------------------------------------------------------------------------
module mtf_datapath
  import mtf_pkg::*;
#(
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ucode_t                        ctrl,
  input  seq_flags_t                    flags,
  input  cfg_t                          cfg,
  input  logic                          channel,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int STATE_W = SAMPLE_BITS + 2;
  localparam int PROD_W  = STATE_W + COEF_W;
  localparam int ACC_W   = STATE_W + 19;
  localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic signed [ACC_W-1:0] STATE_MAX = ACC_W'((longint'(1) << (STATE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] STATE_MIN = -STATE_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] OUT_MAX   = ACC_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] OUT_MIN   = -OUT_MAX - ACC_W'(1);

  logic [IDX_W-1:0]           chan_idx;
  logic [CFG_W-1:0]           gain_clamped;
  logic signed [COEF_W-1:0]   a_op;
  logic signed [STATE_W-1:0]  b_op;
  logic signed [STATE_W-1:0]  x_ext;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    acc;
  logic [4:0]                 shamt;
  logic signed [ACC_W-1:0]    round_bias;
  logic signed [ACC_W-1:0]    rounded;
  logic signed [STATE_W-1:0]  state_val;
  logic signed [STATE_W-1:0]  p_reg;

  logic signed [STATE_W-1:0]  lp_mem     [CHANNELS];
  logic signed [STATE_W-1:0]  hp_out_mem [CHANNELS];
  logic signed [STATE_W-1:0]  hp_in_mem  [CHANNELS];
  logic signed [STATE_W-1:0]  bh_out_mem [CHANNELS];
  logic signed [STATE_W-1:0]  bh_in_mem  [CHANNELS];
  logic signed [STATE_W-1:0]  bp_mem     [CHANNELS];

  // coefficient operand
  always_comb begin
    gain_clamped = (cfg.input_gain > GAIN_MAX) ? GAIN_MAX : cfg.input_gain;
    unique case (ctrl.a_sel)
      A_GAIN:   a_op = {2'b00, gain_clamped};
      A_LP:     a_op = {2'b00, cfg.lowpass_alpha};
      A_LP_INV: a_op = ALPHA_ONE - {2'b00, cfg.lowpass_alpha};
      A_HP:     a_op = {2'b00, cfg.highpass_alpha};
      A_BH:     a_op = {2'b00, cfg.band_highpass_alpha};
      A_BL:     a_op = {2'b00, cfg.band_lowpass_alpha};
      A_BL_INV: a_op = ALPHA_ONE - {2'b00, cfg.band_lowpass_alpha};
      // low 15 bits give morph + 1.0 when negative and morph itself otherwise
      A_MIX:    a_op = {3'b000, cfg.morph[14:0]};
      A_HALF:   a_op = MIX_ONE;
      default:  a_op = '0;
    endcase
  end

  // signal operand
  always_comb begin
    x_ext = STATE_W'(sample_in);
    unique case (ctrl.b_sel)
      B_INPUT:  b_op = x_ext;
      B_P:      b_op = p_reg;
      B_LP:     b_op = lp_mem[chan_idx];
      B_HP_OUT: b_op = hp_out_mem[chan_idx];
      B_HP_IN:  b_op = hp_in_mem[chan_idx];
      B_BH_OUT: b_op = bh_out_mem[chan_idx];
      B_BH_IN:  b_op = bh_in_mem[chan_idx];
      B_BP:     b_op = bp_mem[chan_idx];
      default:  b_op = p_reg;
    endcase
  end

  // multiplier and accumulator
  assign prod_ext = ACC_W'(prod);

  always_ff @(posedge clk) begin
    prod <= a_op * b_op;
    case (ctrl.acc_op)
      ACC_LOAD: acc <= prod_ext;
      ACC_ADD:  acc <= acc + prod_ext;
      ACC_SUB:  acc <= acc - prod_ext;
      default:  acc <= acc;
    endcase
  end

  // round to nearest with halves up, then saturate
  always_comb begin
    unique case (ctrl.wb)
      WB_P:    shamt = GAIN_SHIFT;
      WB_OUT:  shamt = MIX_SHIFT;
      default: shamt = ALPHA_SHIFT;
    endcase
    round_bias = ACC_W'(1) <<< (shamt - 5'd1);
    rounded    = (acc + round_bias) >>> shamt;

    if (rounded > STATE_MAX) begin
      state_val = STATE_MAX[STATE_W-1:0];
    end else if (rounded < STATE_MIN) begin
      state_val = STATE_MIN[STATE_W-1:0];
    end else begin
      state_val = rounded[STATE_W-1:0];
    end

    if (rounded > OUT_MAX) begin
      result = OUT_MAX[SAMPLE_BITS-1:0];
    end else if (rounded < OUT_MIN) begin
      result = OUT_MIN[SAMPLE_BITS-1:0];
    end else begin
      result = rounded[SAMPLE_BITS-1:0];
    end
  end

  // channel of the item in flight and the scaled input
  always_ff @(posedge clk) begin
    if (flags.accept) begin
      chan_idx <= (CHANNELS > 1) ? IDX_W'(channel) : '0;
    end
    if (ctrl.wb == WB_P) begin
      p_reg <= state_val;
    end
  end

  // per-channel filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        lp_mem[i]     <= '0;
        hp_out_mem[i] <= '0;
        hp_in_mem[i]  <= '0;
        bh_out_mem[i] <= '0;
        bh_in_mem[i]  <= '0;
        bp_mem[i]     <= '0;
      end
    end else begin
      case (ctrl.wb)
        WB_LP:   lp_mem[chan_idx]     <= state_val;
        WB_HP:   hp_out_mem[chan_idx] <= state_val;
        WB_BH:   bh_out_mem[chan_idx] <= state_val;
        WB_BP:   bp_mem[chan_idx]     <= state_val;
        default: ;
      endcase
      if (ctrl.save_p) begin
        hp_in_mem[chan_idx] <= p_reg;
        bh_in_mem[chan_idx] <= p_reg;
      end
    end
  end

endmodule

[rtl/morphing_tone_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morphing tone filter
// Per-channel lowpass, highpass and bandpass one-pole sections with input
// gain and a morph crossfade, run by a microcoded multiply-accumulate unit.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_ready    channel, sample_in
//   output    out        out_valid / out_ready  sample_out
//   config    in         cfg_write_en           cfg_index, cfg_data
//
// Each item runs the whole program from acceptance to result: the gain
// product issues in the accepting cycle, then thirteen more products and
// one empty step for the morph sign test go one per cycle through the
// single multiplier; then the accumulator takes the last product and the
// final step rounds it. No new item is taken before that, so items never overlap.
// in_ready is high only while the sequencer waits at its first step.
// A result waits in the output register; the sequencer holds at its last
// step while an earlier result is still not taken.
// Reset loads the register defaults and clears all filter state at once.
// ----------------------------------------------------------------------------
module morphing_tone_filter
  import mtf_pkg::*;
#(
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          channel,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  input  logic                          cfg_write_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  cfg_t                          cfg;
  seq_status_t                   status;
  seq_flags_t                    flags;
  ucode_t                        ctrl;
  logic signed [SAMPLE_BITS-1:0] result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.input_gain          <= GAIN_RESET;
      cfg.morph               <= MORPH_RESET;
      cfg.lowpass_alpha       <= LP_ALPHA_RESET;
      cfg.highpass_alpha      <= HP_ALPHA_RESET;
      cfg.band_highpass_alpha <= BH_ALPHA_RESET;
      cfg.band_lowpass_alpha  <= BL_ALPHA_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_INPUT_GAIN:          cfg.input_gain          <= cfg_data;
        REG_MORPH:               cfg.morph               <= cfg_data;
        REG_LOWPASS_ALPHA:       cfg.lowpass_alpha       <= cfg_data;
        REG_HIGHPASS_ALPHA:      cfg.highpass_alpha      <= cfg_data;
        REG_BAND_HIGHPASS_ALPHA: cfg.band_highpass_alpha <= cfg_data;
        REG_BAND_LOWPASS_ALPHA:  cfg.band_lowpass_alpha  <= cfg_data;
        default: ;
      endcase
    end
  end

  // branch conditions
  assign status.in_valid  = in_valid;
  assign status.morph_neg = cfg.morph[CFG_W-1];
  assign status.out_free  = !out_valid || out_ready;

  mtf_sequencer u_sequencer (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl),
    .flags  (flags)
  );

  mtf_datapath #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .flags     (flags),
    .cfg       (cfg),
    .channel   (channel),
    .sample_in (sample_in),
    .result    (result)
  );

  assign in_ready = flags.idle;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (flags.deliver) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (flags.deliver) begin
      sample_out <= result;
    end
  end

  // accepting an item starts the program, so the block is busy next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high after an item was accepted");

  // a new result comes from the last step and returns the sequencer to idle
  a_result_then_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (in_ready && !$past(in_ready)))
    else $error("result appeared outside the final program step");

  // the sequencer never accepts and delivers in the same cycle
  a_accept_not_deliver: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !flags.deliver)
    else $error("delivery while waiting for an item");

endmodule
